// File: rtl/pfm_pkg.sv
// Shared constants, types and codes for the page frame mapper.
`timescale 1ns / 1ps
`default_nettype none
package pfm_pkg;

	localparam int FRAMES      = 3;
	localparam int IDX_W       = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int PAGE_W      = 15;
	localparam int FRAME_W     = 5;
	localparam int ADDR_W      = 20;
	localparam int SEG_W       = 16;
	localparam int OFF_W       = 4;
	localparam int FRAME_SHIFT = 14;

	localparam logic [ADDR_W-1:0] BASE_RESET = 20'hE0000;

	typedef enum logic [1:0] {
		KIND_MAP     = 2'd0,
		KIND_SAVE    = 2'd1,
		KIND_RESTORE = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef logic [FRAMES-1:0][PAGE_W-1:0] page_arr_t;
	typedef logic [FRAMES-1:0]             valid_vec_t;

	// Decision for one request, from the lookup logic to the table
	typedef struct packed {
		logic               hit;
		logic               issue;
		logic [IDX_W-1:0]   slot;
		logic               adv_ptr;
		logic [IDX_W-1:0]   ptr_next;
		logic [FRAME_W-1:0] frame;
		logic [ADDR_W-1:0]  addr_next;
	} upd_t;

endpackage
`default_nettype wire

// File: rtl/page_frame_mapper.sv
// Top level of the page frame mapper: input register, lookup, table, result register.
// A command taken at a clock edge passes the input register, then the lookup and the result
// register, whose valid bit drives done; one command per cycle.
// Busy stays low and the receiver cannot stall results; table and pointer update at
// the edge that ends the work cycle, so a command in the next cycle sees them.
// Reset (arst_n low) empties table and shadow, clears pointer and addresses; base is 0xE0000.
`timescale 1ns / 1ps
`default_nettype none
module page_frame_mapper (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    kind,
	input  wire logic [pfm_pkg::PAGE_W-1:0]    req_page,
	input  wire logic                          cfg_we,
	input  wire logic [pfm_pkg::ADDR_W-1:0]    cfg_wdata,
	output logic                               done,
	output logic                               hit,
	output logic                               issue_map,
	output logic [pfm_pkg::FRAME_W-1:0]        frame_number,
	output logic [pfm_pkg::SEG_W-1:0]          pointer_segment,
	output logic [pfm_pkg::OFF_W-1:0]          pointer_offset
);

	logic [pfm_pkg::ADDR_W-1:0]       frame_base_q;
	logic                             valid_s1;
	pfm_pkg::kind_t                   kind_s1;
	logic [pfm_pkg::PAGE_W-1:0]       page_s1;
	logic                             valid_s2;
	logic                             hit_s2;
	logic                             issue_s2;
	logic [pfm_pkg::FRAME_W-1:0]      frame_s2;
	logic [pfm_pkg::ADDR_W-1:0]       addr_s2;

	pfm_pkg::page_arr_t               frame_page;
	pfm_pkg::valid_vec_t              frame_valid;
	logic [pfm_pkg::IDX_W-1:0]        replace_ptr;
	logic [pfm_pkg::ADDR_W-1:0]       active_addr;
	logic [pfm_pkg::ADDR_W-1:0]       shadow_addr;
	pfm_pkg::upd_t                    upd;

	assign busy = 1'b0;

	// Hold the frame base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= pfm_pkg::BASE_RESET;
		end else if (cfg_we) begin
			frame_base_q <= cfg_wdata;
		end
	end

	// Capture the command on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_s1 <= pfm_pkg::kind_t'(kind);
			page_s1 <= req_page;
		end
	end

	pfm_lookup u_lookup (
		.kind        (kind_s1),
		.page        (page_s1),
		.frame_base  (frame_base_q),
		.frame_page  (frame_page),
		.frame_valid (frame_valid),
		.replace_ptr (replace_ptr),
		.active_addr (active_addr),
		.shadow_addr (shadow_addr),
		.upd         (upd)
	);

	pfm_table u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (valid_s1),
		.kind        (kind_s1),
		.page        (page_s1),
		.upd         (upd),
		.frame_page  (frame_page),
		.frame_valid (frame_valid),
		.replace_ptr (replace_ptr),
		.active_addr (active_addr),
		.shadow_addr (shadow_addr)
	);

	// Register the result and its strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			hit_s2   <= upd.hit;
			issue_s2 <= upd.issue;
			frame_s2 <= upd.frame;
			addr_s2  <= upd.addr_next;
		end
	end

	assign done            = valid_s2;
	assign hit             = hit_s2;
	assign issue_map       = issue_s2;
	assign frame_number    = frame_s2;
	assign pointer_segment = addr_s2[pfm_pkg::ADDR_W-1:pfm_pkg::OFF_W];
	assign pointer_offset  = addr_s2[pfm_pkg::OFF_W-1:0];

endmodule
`default_nettype wire

// File: rtl/pfm_lookup.sv
// Associative lookup, fill/replace choice and frame address computation.
`timescale 1ns / 1ps
`default_nettype none
module pfm_lookup (
	input  wire pfm_pkg::kind_t                 kind,
	input  wire logic [pfm_pkg::PAGE_W-1:0]     page,
	input  wire logic [pfm_pkg::ADDR_W-1:0]     frame_base,
	input  wire pfm_pkg::page_arr_t             frame_page,
	input  wire pfm_pkg::valid_vec_t            frame_valid,
	input  wire logic [pfm_pkg::IDX_W-1:0]      replace_ptr,
	input  wire logic [pfm_pkg::ADDR_W-1:0]     active_addr,
	input  wire logic [pfm_pkg::ADDR_W-1:0]     shadow_addr,
	output pfm_pkg::upd_t                       upd
);

	logic                        hit_found;
	logic [pfm_pkg::IDX_W-1:0]   hit_idx;
	logic                        empty_found;
	logic [pfm_pkg::IDX_W-1:0]   empty_idx;
	logic [pfm_pkg::IDX_W-1:0]   victim;
	logic [pfm_pkg::IDX_W:0]     victim_inc;
	logic [pfm_pkg::IDX_W-1:0]   slot;
	logic [pfm_pkg::FRAME_W-1:0] frame;
	logic [pfm_pkg::ADDR_W-1:0]  map_addr;

	// Find lowest matching frame and lowest empty frame
	always_comb begin
		hit_found   = 1'b0;
		hit_idx     = '0;
		empty_found = 1'b0;
		empty_idx   = '0;
		for (int i = pfm_pkg::FRAMES - 1; i >= 0; i--) begin
			if (frame_valid[i] && (frame_page[i] == page)) begin
				hit_found = 1'b1;
				hit_idx   = pfm_pkg::IDX_W'(i);
			end
			if (!frame_valid[i]) begin
				empty_found = 1'b1;
				empty_idx   = pfm_pkg::IDX_W'(i);
			end
		end
	end

	// Round-robin victim and its wrapped successor
	always_comb begin
		victim     = ({1'b0, replace_ptr} < (pfm_pkg::IDX_W + 1)'(pfm_pkg::FRAMES))
			? replace_ptr : '0;
		victim_inc = {1'b0, victim} + (pfm_pkg::IDX_W + 1)'(1);
	end

	assign slot = hit_found ? hit_idx : (empty_found ? empty_idx : victim);
	assign frame = pfm_pkg::FRAME_W'(slot) + pfm_pkg::FRAME_W'(1);
	assign map_addr = frame_base
		+ (pfm_pkg::ADDR_W'(frame) << pfm_pkg::FRAME_SHIFT);

	// Build the decision for the current request kind
	always_comb begin
		upd.hit       = 1'b0;
		upd.issue     = 1'b0;
		upd.slot      = slot;
		upd.adv_ptr   = 1'b0;
		upd.ptr_next  = (victim_inc >= (pfm_pkg::IDX_W + 1)'(pfm_pkg::FRAMES))
			? '0 : victim_inc[pfm_pkg::IDX_W-1:0];
		upd.frame     = '0;
		upd.addr_next = active_addr;
		unique case (kind)
			pfm_pkg::KIND_MAP: begin
				upd.hit       = hit_found;
				upd.issue     = !hit_found;
				upd.adv_ptr   = !hit_found && !empty_found;
				upd.frame     = frame;
				upd.addr_next = map_addr;
			end
			pfm_pkg::KIND_RESTORE: begin
				upd.addr_next = shadow_addr;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/pfm_table.sv
// Frame table, shadow copy, replacement pointer and active address registers.
`timescale 1ns / 1ps
`default_nettype none
module pfm_table (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire pfm_pkg::kind_t                kind,
	input  wire logic [pfm_pkg::PAGE_W-1:0]    page,
	input  wire pfm_pkg::upd_t                 upd,
	output pfm_pkg::page_arr_t                 frame_page,
	output pfm_pkg::valid_vec_t                frame_valid,
	output logic [pfm_pkg::IDX_W-1:0]          replace_ptr,
	output logic [pfm_pkg::ADDR_W-1:0]         active_addr,
	output logic [pfm_pkg::ADDR_W-1:0]         shadow_addr
);

	pfm_pkg::page_arr_t               frame_page_q;
	pfm_pkg::valid_vec_t              frame_valid_q;
	logic [pfm_pkg::IDX_W-1:0]        replace_ptr_q;
	logic [pfm_pkg::ADDR_W-1:0]       active_addr_q;
	pfm_pkg::page_arr_t               shadow_page_q;
	pfm_pkg::valid_vec_t              shadow_valid_q;
	logic [pfm_pkg::ADDR_W-1:0]       shadow_addr_q;

	// Update control state: valid bits, pointer, addresses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q  <= '0;
			replace_ptr_q  <= '0;
			active_addr_q  <= '0;
			shadow_valid_q <= '0;
			shadow_addr_q  <= '0;
		end else if (en) begin
			active_addr_q <= upd.addr_next;
			unique case (kind)
				pfm_pkg::KIND_MAP: begin
					if (upd.issue) begin
						frame_valid_q[upd.slot] <= 1'b1;
					end
					if (upd.adv_ptr) begin
						replace_ptr_q <= upd.ptr_next;
					end
				end
				pfm_pkg::KIND_SAVE: begin
					shadow_valid_q <= frame_valid_q;
					shadow_addr_q  <= active_addr_q;
				end
				pfm_pkg::KIND_RESTORE: begin
					frame_valid_q <= shadow_valid_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Update page payload; valid bits guard unwritten entries
	always_ff @(posedge clk) begin
		if (en) begin
			unique case (kind)
				pfm_pkg::KIND_MAP: begin
					if (upd.issue) begin
						frame_page_q[upd.slot] <= page;
					end
				end
				pfm_pkg::KIND_SAVE: begin
					shadow_page_q <= frame_page_q;
				end
				pfm_pkg::KIND_RESTORE: begin
					frame_page_q <= shadow_page_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign frame_page  = frame_page_q;
	assign frame_valid = frame_valid_q;
	assign replace_ptr = replace_ptr_q;
	assign active_addr = active_addr_q;
	assign shadow_addr = shadow_addr_q;

endmodule
`default_nettype wire

// File: verif/page_frame_mapper_tb.sv
// Self-checking testbench for the page frame mapper: random and directed commands.
`timescale 1ns / 1ps
`default_nettype none
module page_frame_mapper_tb;

	// Fields of one result transfer
	typedef struct {
		bit                        hit;
		bit                        issue;
		bit [pfm_pkg::FRAME_W-1:0] frame;
		bit [pfm_pkg::SEG_W-1:0]   seg;
		bit [pfm_pkg::OFF_W-1:0]   off;
	} frame_result_t;

	// Predicts the frame table and checks results in order
	class frame_table_scoreboard;
		bit [pfm_pkg::ADDR_W-1:0] frame_base = pfm_pkg::BASE_RESET;
		bit [pfm_pkg::PAGE_W-1:0] pages [pfm_pkg::FRAMES];
		bit                       held [pfm_pkg::FRAMES];
		int                       rr_slot;
		bit [pfm_pkg::ADDR_W-1:0] active_addr;
		bit [pfm_pkg::PAGE_W-1:0] saved_pages [pfm_pkg::FRAMES];
		bit                       saved_held [pfm_pkg::FRAMES];
		bit [pfm_pkg::ADDR_W-1:0] saved_addr;
		frame_result_t            expected_results [$];
		int                       fail_count;

		function int pending();
			return expected_results.size();
		endfunction

		function void report(string msg);
			fail_count++;
			if (fail_count <= 10)
				$display("%s", msg);
		endfunction

		// Apply one accepted command and queue the result it must produce
		function void note_command(pfm_pkg::kind_t k, bit [pfm_pkg::PAGE_W-1:0] pg);
			frame_result_t r;
			int slot;
			r.hit = 0;
			r.issue = 0;
			r.frame = 0;
			case (k)
				pfm_pkg::KIND_MAP: begin
					slot = -1;
					for (int i = 0; i < pfm_pkg::FRAMES; i++)
						if (slot < 0 && held[i] && pages[i] == pg)
							slot = i;
					if (slot >= 0) begin
						r.hit = 1;
					end else begin
						r.issue = 1;
						for (int i = 0; i < pfm_pkg::FRAMES; i++)
							if (slot < 0 && !held[i])
								slot = i;
						// all frames taken: replace round-robin and advance
						if (slot < 0) begin
							slot = rr_slot;
							rr_slot = (rr_slot + 1 >= pfm_pkg::FRAMES) ? 0 : rr_slot + 1;
						end
						pages[slot] = pg;
						held[slot] = 1;
					end
					r.frame = pfm_pkg::FRAME_W'(slot + 1);
					active_addr = frame_base
						+ (pfm_pkg::ADDR_W'(slot + 1) << pfm_pkg::FRAME_SHIFT);
				end
				pfm_pkg::KIND_SAVE: begin
					saved_pages = pages;
					saved_held = held;
					saved_addr = active_addr;
				end
				pfm_pkg::KIND_RESTORE: begin
					pages = saved_pages;
					held = saved_held;
					active_addr = saved_addr;
				end
				default: ;
			endcase
			r.seg = active_addr[pfm_pkg::ADDR_W-1:pfm_pkg::OFF_W];
			r.off = active_addr[pfm_pkg::OFF_W-1:0];
			expected_results.push_back(r);
		endfunction

		// Compare one result transfer against the oldest expectation
		function void check_result(bit h, bit im, bit [pfm_pkg::FRAME_W-1:0] fn,
				bit [pfm_pkg::SEG_W-1:0] seg, bit [pfm_pkg::OFF_W-1:0] off);
			frame_result_t e;
			if (expected_results.size() == 0) begin
				report($sformatf("unexpected result: hit=%0d map=%0d frame=%0d seg=%h off=%h",
					h, im, fn, seg, off));
				return;
			end
			e = expected_results.pop_front();
			if (e.hit != h || e.issue != im || e.frame != fn || e.seg != seg || e.off != off)
				report($sformatf({"mismatch: expected hit=%0d map=%0d frame=%0d seg=%h off=%h,",
					" got hit=%0d map=%0d frame=%0d seg=%h off=%h"},
					e.hit, e.issue, e.frame, e.seg, e.off, h, im, fn, seg, off));
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic [1:0]                   kind = pfm_pkg::KIND_MAP;
	logic [pfm_pkg::PAGE_W-1:0]   req_page = '0;
	logic                         cfg_we = 1'b0;
	logic [pfm_pkg::ADDR_W-1:0]   cfg_wdata = '0;
	logic                         busy;
	logic                         done;
	logic                         hit;
	logic                         issue_map;
	logic [pfm_pkg::FRAME_W-1:0]  frame_number;
	logic [pfm_pkg::SEG_W-1:0]    pointer_segment;
	logic [pfm_pkg::OFF_W-1:0]    pointer_offset;

	frame_table_scoreboard sb;
	bit idle_on = 1'b1;

	page_frame_mapper uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.req_page(req_page),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.hit(hit),
		.issue_map(issue_map),
		.frame_number(frame_number),
		.pointer_segment(pointer_segment),
		.pointer_offset(pointer_offset)
	);

	always #2 clk = ~clk;

	// Track register writes, accepted commands and result transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.frame_base = cfg_wdata;
			if (start && !busy)
				sb.note_command(pfm_pkg::kind_t'(kind), req_page);
			if (done)
				sb.check_result(hit, issue_map, frame_number, pointer_segment,
					pointer_offset);
		end
	end

	// Present one command, after a random gap when gaps are on, and hold it until taken
	task automatic send_command(input pfm_pkg::kind_t k,
			input logic [pfm_pkg::PAGE_W-1:0] pg);
		int gap;
		gap = idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		req_page <= pg;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and wait until every result has come
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() > 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_base(input logic [pfm_pkg::ADDR_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly map requests over a small page pool, so hits and replacements both occur
	task automatic run_random_phase(input int count);
		logic [pfm_pkg::PAGE_W-1:0] pool [6];
		int pool_size;
		int pick;
		pool_size = $urandom_range(2, 6);
		for (int i = 0; i < 6; i++)
			pool[i] = pfm_pkg::PAGE_W'($urandom());
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (n == count / 2)
				drain_results();
			pick = $urandom_range(0, 99);
			if (pick < 78)
				send_command(pfm_pkg::KIND_MAP, pool[$urandom_range(0, pool_size - 1)]);
			else if (pick < 84)
				send_command(pfm_pkg::KIND_MAP, pfm_pkg::PAGE_W'($urandom()));
			else if (pick < 91)
				send_command(pfm_pkg::KIND_SAVE, pfm_pkg::PAGE_W'($urandom()));
			else if (pick < 97)
				send_command(pfm_pkg::KIND_RESTORE, pfm_pkg::PAGE_W'($urandom()));
			else
				send_command(pfm_pkg::KIND_NONE, pfm_pkg::PAGE_W'($urandom()));
		end
	endtask

	initial begin
		logic [pfm_pkg::ADDR_W-1:0] bases [6];
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: restore before any save, unused kind, empty frames, replacement
		send_command(pfm_pkg::KIND_RESTORE, 15'h0000);
		send_command(pfm_pkg::KIND_NONE, 15'h7FFF);
		send_command(pfm_pkg::KIND_MAP, 15'h0000);
		send_command(pfm_pkg::KIND_MAP, 15'h7FFF);
		send_command(pfm_pkg::KIND_MAP, 15'h0000);
		send_command(pfm_pkg::KIND_MAP, 15'h0001);
		send_command(pfm_pkg::KIND_MAP, 15'h0002);
		send_command(pfm_pkg::KIND_SAVE, 15'h7FFF);
		send_command(pfm_pkg::KIND_MAP, 15'h7FFF);
		send_command(pfm_pkg::KIND_MAP, 15'h5555);
		send_command(pfm_pkg::KIND_RESTORE, 15'h0000);
		send_command(pfm_pkg::KIND_MAP, 15'h7FFF);
		send_command(pfm_pkg::KIND_MAP, 15'h2AAA);
		send_command(pfm_pkg::KIND_NONE, 15'h0000);
		send_command(pfm_pkg::KIND_SAVE, 15'h0000);
		send_command(pfm_pkg::KIND_MAP, 15'h1234);
		send_command(pfm_pkg::KIND_RESTORE, 15'h7FFF);
		send_command(pfm_pkg::KIND_MAP, 15'h0000);
		drain_results();

		// Run random phases over extreme and random frame bases
		bases[0] = 20'hFFFFF;
		bases[1] = 20'h00000;
		bases[2] = 20'hFC000;
		bases[3] = pfm_pkg::ADDR_W'($urandom());
		bases[4] = pfm_pkg::ADDR_W'($urandom());
		bases[5] = pfm_pkg::BASE_RESET;
		for (int p = 0; p < 6; p++) begin
			write_base(bases[p]);
			run_random_phase(200);
			drain_results();
		end

		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Stop a hung run
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire

// File: sim.f
rtl/pfm_pkg.sv
rtl/pfm_lookup.sv
rtl/pfm_table.sv
rtl/page_frame_mapper.sv
verif/page_frame_mapper_tb.sv
